### hw/rtl/signed_int_to_decimal_ascii_unit_macros.svh
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_macros.svh
// assertion macros shared by the decimal ascii unit
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ITDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ITDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/itda_pkg.sv
// ---------------------------------------------------------------------------
// itda_pkg
// shared constants, types and helpers of the decimal ascii unit
// ---------------------------------------------------------------------------
package itda_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [3:0] DIGIT_NINE = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} itda_state_t;

	// shift-and-add-3 correction of one bcd digit
	function automatic logic [3:0] add3(input logic [3:0] d);
		add3 = (d >= 4'd5) ? d + 4'd3 : d;
	endfunction

endpackage

### hw/rtl/itda_bcd_conv.sv
// ---------------------------------------------------------------------------
// itda_bcd_conv
// bit-serial binary to bcd converter, one magnitude bit per cycle
// ---------------------------------------------------------------------------
module itda_bcd_conv #(
	parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [VALUE_WIDTH-1:0]                       mag,
	output logic                                         done,
	output logic [((VALUE_WIDTH*3)/10+1)*4-1:0]          bcd
);
	import itda_pkg::*;

	localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
	localparam int BCD_WIDTH  = NUM_DIGITS * 4;
	localparam int CNT_WIDTH  = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_WIDTH-1:0]   bcd_q;
	logic [BCD_WIDTH-1:0]   bcd_adj;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic                   busy_q;
	logic                   done_q;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[i*4 +: 4] = add3(bcd_q[i*4 +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {bcd_adj[BCD_WIDTH-2:0], bin_q[VALUE_WIDTH-1]};
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

### hw/rtl/signed_int_to_decimal_ascii_unit.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// signed two's complement integer to decimal ascii text, one char per word
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall, value) takes one signed integer per word.
// Output channel (out_valid/out_stall, character, last) gives its decimal
// text, most significant character first: '-' for a negative value, then
// the digits with leading zeros dropped; zero gives a single '0'. last marks
// the final character of each number.
// Timing: the magnitude runs through a shift-and-add-3 converter at one bit
// per cycle; the digits are then loaded and leading zeros are shifted out
// one at a time. Characters then leave at one per cycle while the output
// is not stalled. in_stall is high while a number is in work and drops as
// soon as its last character sits in the output register.
// A stall on the output holds the current character and pauses emission.
// Reset puts the unit idle with no output word pending.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = itda_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    character,
	output logic                          last
);
	import itda_pkg::*;

	`include "signed_int_to_decimal_ascii_unit_macros.svh"

	localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
	localparam int BCD_WIDTH  = NUM_DIGITS * 4;
	localparam int NCNT_WIDTH = $clog2(NUM_DIGITS + 1);

	itda_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] val_u;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   conv_start;
	logic                   conv_done;
	logic [BCD_WIDTH-1:0]   conv_bcd;

	logic [BCD_WIDTH-1:0]   dig_q;
	logic [NCNT_WIDTH-1:0]  cnt_q;
	logic                   neg_q;
	logic [3:0]             top_digit;

	logic                   load_dig;
	logic                   shift_dig;
	logic                   clr_neg;
	logic                   load_out;
	logic                   can_load;
	logic [7:0]             char_d;
	logic                   last_d;

	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;

	assign val_u     = value;
	assign mag       = val_u[VALUE_WIDTH-1] ?
		(~val_u) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : val_u;
	assign top_digit = dig_q[BCD_WIDTH-1 -: 4];
	assign can_load  = !out_valid_q || !out_stall;

	itda_bcd_conv #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_conv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (conv_start),
		.mag   (mag),
		.done  (conv_done),
		.bcd   (conv_bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		conv_start = 1'b0;
		load_dig   = 1'b0;
		shift_dig  = 1'b0;
		clr_neg    = 1'b0;
		load_out   = 1'b0;
		char_d     = CHAR_ZERO;
		last_d     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					conv_start = 1'b1;
					state_d    = ST_CONV;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					load_dig = 1'b1;
					state_d  = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (top_digit == 4'd0 && cnt_q > NCNT_WIDTH'(1)) begin
					shift_dig = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (can_load) begin
					load_out = 1'b1;
					if (neg_q) begin
						char_d  = CHAR_MINUS;
						clr_neg = 1'b1;
					end else begin
						char_d    = CHAR_ZERO + {4'd0, top_digit};
						shift_dig = 1'b1;
						if (cnt_q == NCNT_WIDTH'(1)) begin
							last_d  = 1'b1;
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else begin
			if (conv_start) begin
				neg_q <= val_u[VALUE_WIDTH-1];
			end else if (clr_neg) begin
				neg_q <= 1'b0;
			end
			if (load_dig) begin
				cnt_q <= NCNT_WIDTH'(NUM_DIGITS);
			end else if (shift_dig) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_dig) begin
			dig_q <= conv_bcd;
		end else if (shift_dig) begin
			dig_q <= {dig_q[BCD_WIDTH-5:0], 4'd0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	`ITDA_ASSERT_NEXT(a_accept_starts_conv, in_valid && !in_stall, state_q == ST_CONV,
		"accepted word did not start a conversion")
	`ITDA_ASSERT_NOW(a_done_in_conv, conv_done, state_q == ST_CONV,
		"converter finished outside the conversion state")
	`ITDA_ASSERT_NOW(a_emit_has_digits, state_q == ST_EMIT, cnt_q != '0,
		"emitting with no digits left")
	`ITDA_ASSERT_NOW(a_minus_not_last, out_valid && character == CHAR_MINUS, !last,
		"minus sign flagged as last character")
	`ITDA_ASSERT_NOW(a_digit_range, out_valid && character != CHAR_MINUS,
		character >= CHAR_ZERO && character <= CHAR_ZERO + 8'(DIGIT_NINE),
		"output character is not a digit")

endmodule

### tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for signed_int_to_decimal_ascii_unit
// ---------------------------------------------------------------------------
// A queue of integers feeds a clocked driver. Each accepted word is turned
// into its expected decimal text, one entry per character with its last
// flag. A clocked monitor checks every output word against the oldest
// entry. The stimulus starts with edge values (zero, the most negative
// value, the largest value, decade boundaries, every digit). It goes on with
// random values of every length, values close to powers of ten, small values
// and fully random words. Both sides pause at random, with a quiet window of
// no pauses in the middle of the run.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import itda_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} text_char_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic signed [31:0] value     = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         character;
	logic               last;

	logic [31:0] pending_values[$];
	text_char_t  expected_text[$];
	int          fail_count = 0;
	int          cycle_count = 0;

	signed_int_to_decimal_ascii_unit #(
		.VALUE_WIDTH(32)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.character(character),
		.last     (last)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic bit take_gap();
		if (cycle_count >= 6000 && cycle_count < 10000)
			return 1'b0;
		return $urandom_range(99) < 6;
	endfunction

	function automatic void predict_text(input logic [31:0] v);
		logic [31:0] mag;
		logic [3:0]  digs[10];
		int          n;
		mag = v[31] ? (~v + 32'd1) : v;
		n = 0;
		if (v[31])
			expected_text.push_back('{CHAR_MINUS, 1'b0});
		do begin
			digs[n] = 4'(mag % 32'd10);
			mag = mag / 32'd10;
			n++;
		end while (mag != 0);
		for (int i = n - 1; i >= 0; i--)
			expected_text.push_back('{8'(CHAR_ZERO + digs[i]), i == 0});
	endfunction

	function automatic logic [31:0] random_value();
		longint lo, hi, cap, mag;
		int     n, kind;
		bit     neg;
		kind = $urandom_range(3);
		n = $urandom_range(10, 1);
		neg = $urandom_range(1);
		cap = neg ? 64'd2147483648 : 64'd2147483647;
		lo = 1;
		for (int i = 1; i < n; i++)
			lo = lo * 10;
		hi = (n == 10) ? cap : lo * 10 - 1;
		case (kind)
			0: begin
				return $urandom;
			end
			1: begin
				mag = lo + $urandom_range(32'(hi - lo));
			end
			2: begin
				mag = ($urandom_range(1) ? lo : hi) - 2 + $urandom_range(4);
				if (mag < 0)
					mag = 0;
				if (mag > cap)
					mag = cap;
			end
			default: begin
				mag = $urandom_range(20);
			end
		endcase
		return neg ? 32'(-mag) : 32'(mag);
	endfunction

	// driver
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_text(value);
			if (!in_valid || !in_stall) begin
				if (pending_values.size() != 0 && !take_gap()) begin
					value <= pending_values.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		text_char_t exp_char;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected word char %0d last %0b",
						character, last));
				end else begin
					exp_char = expected_text.pop_front();
					if (character !== exp_char.ch)
						report_mismatch($sformatf("character %0d, expected %0d",
							character, exp_char.ch));
					if (last !== exp_char.fin)
						report_mismatch($sformatf("last %0b, expected %0b",
							last, exp_char.fin));
				end
			end
			out_stall <= take_gap();
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("FAIL signed_int_to_decimal_ascii_unit");
		$finish;
	end

	initial begin
		pending_values.push_back(32'sd0);
		pending_values.push_back(32'sd1);
		pending_values.push_back(-32'sd1);
		pending_values.push_back(32'sd9);
		pending_values.push_back(-32'sd9);
		pending_values.push_back(32'sd10);
		pending_values.push_back(-32'sd10);
		pending_values.push_back(32'sd99);
		pending_values.push_back(32'sd100);
		pending_values.push_back(-32'sd100);
		pending_values.push_back(32'sd1234567890);
		pending_values.push_back(-32'sd987654321);
		pending_values.push_back(32'sd999999999);
		pending_values.push_back(32'sd1000000000);
		pending_values.push_back(-32'sd1000000000);
		pending_values.push_back(32'sd2147483647);
		pending_values.push_back(-32'sd2147483647);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h5555_5555);
		pending_values.push_back(32'hAAAA_AAAA);
		repeat (360)
			pending_values.push_back(random_value());
		wait (arst_n);
		while (pending_values.size() != 0 || in_valid || expected_text.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("PASS signed_int_to_decimal_ascii_unit");
		else
			$display("FAIL signed_int_to_decimal_ascii_unit");
		$finish;
	end

endmodule
